/* src/msl_pkg.sv */
// shared types, constants and state codes for the merge-by-rank unit
package msl_pkg;

   localparam int LEN_A_DEF = 8;
   localparam int LEN_B_DEF = 8;
   localparam int BURST_MAX = 16;
   localparam int IDX_W     = 7;
   localparam int BCNT_W    = 5;
   localparam int ADDR_W    = 5;

   typedef struct packed {
      logic               action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_res;
      logic [3:0]         position;
      logic               from_b;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]  start_idx;
      logic [BCNT_W-1:0] count;
      logic              last_run;
   } cmd_type;

   typedef struct packed {
      logic               we_a;
      logic               we_b;
      logic [ADDR_W-1:0]  addr;
      logic signed [31:0] data;
   } wr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN
   } back_state_type;

endpackage

/* src/msl_front.sv */
// load side: list fill counters, list writes and emission burst commands
module msl_front import msl_pkg::*; #(
   parameter int LEN_A = LEN_A_DEF,
   parameter int LEN_B = LEN_B_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   input  q_stat_type q_stat,
   input  logic       back_busy,
   output logic       cmd_push,
   output cmd_type    cmd,
   output wr_type     wr
);

   localparam int TOTAL = LEN_A + LEN_B;
   localparam int CAW   = $clog2(LEN_A + 1);
   localparam int CBW   = $clog2(LEN_B + 1);
   localparam int IW    = $clog2(TOTAL + 1);

   logic [CAW-1:0]   cnt_a_ff, cnt_a_in, cnt_a_nx;
   logic [CBW-1:0]   cnt_b_ff, cnt_b_in, cnt_b_nx;
   logic [IW-1:0]    emit_ff, emit_in;
   logic             accept, a_full, b_full, wr_a, wr_b, fin;
   logic [IDX_W-1:0] remaining;

   assign a_full = (cnt_a_ff == CAW'(LEN_A));
   assign b_full = (cnt_b_ff == CBW'(LEN_B));
   // while a finished run is still draining the lists may not be rewritten
   assign busy   = q_stat.full || (!(a_full && b_full) && (back_busy || !q_stat.empty));
   assign accept = start && !busy;
   assign wr_a   = accept && !req_data.action && !a_full;
   assign wr_b   = accept && req_data.action && !b_full;

   assign cnt_a_nx  = cnt_a_ff + CAW'(wr_a);
   assign cnt_b_nx  = cnt_b_ff + CBW'(wr_b);
   assign remaining = IDX_W'(TOTAL) - IDX_W'(emit_ff);
   assign fin       = (remaining <= IDX_W'(BURST_MAX));

   always_comb begin
      cmd_push      = accept && (cnt_a_nx == CAW'(LEN_A)) && (cnt_b_nx == CBW'(LEN_B));
      cmd.start_idx = IDX_W'(emit_ff);
      cmd.count     = fin ? remaining[BCNT_W-1:0] : BCNT_W'(BURST_MAX);
      cmd.last_run  = fin;
      cnt_a_in      = cnt_a_nx;
      cnt_b_in      = cnt_b_nx;
      emit_in       = emit_ff;
      if (cmd_push) begin
         if (fin) begin
            cnt_a_in = '0;
            cnt_b_in = '0;
            emit_in  = '0;
         end else begin
            emit_in = emit_ff + IW'(BURST_MAX);
         end
      end
   end

   always_comb begin
      wr.we_a = wr_a;
      wr.we_b = wr_b;
      wr.addr = req_data.action ? ADDR_W'(cnt_b_ff) : ADDR_W'(cnt_a_ff);
      wr.data = req_data.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         emit_ff  <= '0;
      end else begin
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         emit_ff  <= emit_in;
      end
   end

endmodule

/* src/msl_cmdq.sv */
// two-entry command queue between load side and emission sequencer
module msl_cmdq import msl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_cmd,
   input  logic       pop,
   output cmd_type    head,
   output q_stat_type stat
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign head       = slot_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

/* src/msl_back.sv */
// emission side: list memories and rank sequencer, one compare per cycle while scanning
module msl_back import msl_pkg::*; #(
   parameter int LEN_A = LEN_A_DEF,
   parameter int LEN_B = LEN_B_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  wr_type  wr,
   input  cmd_type cmd,
   input  logic    cmd_avail,
   output logic    cmd_pop,
   output logic    back_busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int TOTAL = LEN_A + LEN_B;
   localparam int AW_A  = (LEN_A > 1) ? $clog2(LEN_A) : 1;
   localparam int AW_B  = (LEN_B > 1) ? $clog2(LEN_B) : 1;
   localparam int MAXL  = (LEN_A > LEN_B) ? LEN_A : LEN_B;
   localparam int TW    = $clog2(MAXL + 1);
   localparam int IW    = $clog2(TOTAL + 1);
   localparam int PW    = (IW + 1 > 4) ? IW + 1 : 4;

   logic signed [31:0] mem_a [LEN_A];
   logic signed [31:0] mem_b [LEN_B];
   logic signed [31:0] rd_a_ff, rd_b_ff, piv, scan;

   back_state_type    state_ff, state_in;
   logic [IW-1:0]     idx_ff, idx_in, piv_j, local_idx;
   logic [BCNT_W-1:0] remain_ff, remain_in;
   logic              last_run_ff, last_run_in;
   logic [TW-1:0]     t_ff, t_in, cnt_ff, cnt_in, scan_len;
   logic              cmp_vld_ff, rsp_vld_ff, rsp_vld_in, from_b, lt;
   logic [AW_A-1:0]   addr_a;
   logic [AW_B-1:0]   addr_b;
   logic [PW-1:0]     pos_sum;
   rsp_type           rsp_ff, rsp_in;

   // pivot address holds for a whole element, scan address walks the other list
   assign from_b   = (idx_ff >= IW'(LEN_A));
   assign piv_j    = idx_ff - IW'(LEN_A);
   assign scan_len = from_b ? TW'(LEN_A) : TW'(LEN_B);
   assign addr_a   = from_b ? t_ff[AW_A-1:0] : idx_ff[AW_A-1:0];
   assign addr_b   = from_b ? piv_j[AW_B-1:0] : t_ff[AW_B-1:0];
   assign piv      = from_b ? rd_b_ff : rd_a_ff;
   assign scan     = from_b ? rd_a_ff : rd_b_ff;
   // ties: b ranks after equal a entries
   assign lt       = from_b ? (scan <= piv) : (scan < piv);
   assign local_idx = from_b ? piv_j : idx_ff;
   assign pos_sum   = PW'(local_idx) + PW'(cnt_ff) + PW'(lt);

   always_ff @(posedge clock) begin
      if (wr.we_a) begin
         mem_a[wr.addr[AW_A-1:0]] <= wr.data;
      end
      if (wr.we_b) begin
         mem_b[wr.addr[AW_B-1:0]] <= wr.data;
      end
      rd_a_ff <= mem_a[addr_a];
      rd_b_ff <= mem_b[addr_b];
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      remain_in   = remain_ff;
      last_run_in = last_run_ff;
      t_in        = t_ff;
      cnt_in      = cnt_ff;
      rsp_vld_in  = 1'b0;
      rsp_in      = rsp_ff;
      cmd_pop     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_avail) begin
               cmd_pop     = 1'b1;
               idx_in      = cmd.start_idx[IW-1:0];
               remain_in   = cmd.count;
               last_run_in = cmd.last_run;
               t_in        = '0;
               cnt_in      = '0;
               state_in    = BK_SCAN;
            end
         end
         BK_SCAN: begin
            cnt_in = cnt_ff + TW'(cmp_vld_ff & lt);
            t_in   = t_ff + TW'(1);
            if (t_ff == scan_len - TW'(1)) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            rsp_vld_in       = 1'b1;
            rsp_in.value_res = piv;
            rsp_in.position  = pos_sum[3:0];
            rsp_in.from_b    = from_b;
            rsp_in.last      = last_run_ff && (remain_ff == BCNT_W'(1));
            idx_in           = idx_ff + IW'(1);
            remain_in        = remain_ff - BCNT_W'(1);
            t_in             = '0;
            cnt_in           = '0;
            state_in         = (remain_ff == BCNT_W'(1)) ? BK_IDLE : BK_SCAN;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= (state_ff == BK_SCAN);
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      remain_ff   <= remain_in;
      last_run_ff <= last_run_in;
      t_ff        <= t_in;
      cnt_ff      <= cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign back_busy = (state_ff != BK_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/merge_sorted_lists_by_rank_unit.sv */
// top level of the merge-by-rank unit: load side, command queue, emission side
//
//   channel   ports                      handshake
//   request   start, busy, req_data      beat taken when start high and busy low
//   response  rsp_valid, rsp_data        one-cycle strobe, receiver cannot stall
//
// a request beat taken while its list is not full is written straight into list memory
// each result takes one compare per entry of the other list, one compare per cycle
//   on the registered memory read port, the last one together with the output load
// a beat that completes both lists queues a burst of up to 16 results
// reset is synchronous: clears fill counts, queue and sequencer, lists are not cleared
// busy is high while the queue is full, or while a finished run still drains
//   and the lists are open for new data again
module merge_sorted_lists_by_rank_unit import msl_pkg::*; #(
   parameter int LEN_A = LEN_A_DEF,
   parameter int LEN_B = LEN_B_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   q_stat_type q_stat;
   cmd_type    push_cmd, head_cmd;
   wr_type     wr;
   logic       cmd_push, cmd_pop, back_busy;

   // load side owns the fill counts and decides when bursts go out
   msl_front #(
      .LEN_A(LEN_A),
      .LEN_B(LEN_B)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_stat   (q_stat),
      .back_busy(back_busy),
      .cmd_push (cmd_push),
      .cmd      (push_cmd),
      .wr       (wr)
   );

   // burst commands wait here while the sequencer works
   msl_cmdq u_cmdq (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .push_cmd(push_cmd),
      .pop     (cmd_pop),
      .head    (head_cmd),
      .stat    (q_stat)
   );

   // rank each element against the other list, one element at a time
   msl_back #(
      .LEN_A(LEN_A),
      .LEN_B(LEN_B)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .cmd      (head_cmd),
      .cmd_avail(!q_stat.empty),
      .cmd_pop  (cmd_pop),
      .back_busy(back_busy),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

/* src/msl_checker.sv */
// port-level checks for the merge-by-rank unit and their bind
module msl_checker import msl_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // every result is preceded by its compare scan, so strobes never touch
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // nothing queued or in flight after reset, so the block takes beats at once
   a_reset_ready: assert property (@(posedge clock)
      reset |=> !busy)
      else $error("busy right after reset");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> !$isunknown(req_data))
      else $error("request beat with unknown payload");

   // b entries come out after all a entries, so the run ends on a b entry
   a_last_from_b: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> rsp_data.from_b)
      else $error("run ended on an a entry");

endmodule

bind merge_sorted_lists_by_rank_unit msl_checker u_msl_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);
